/* rtl/blas1_vector_engine_core_defines.svh */
// Assertion macros for the checker of the BLAS level-1 engine.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BLAS1_VECTOR_ENGINE_CORE_DEFINES_SVH
`define BLAS1_VECTOR_ENGINE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLAS1VE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blas1 vector engine: same-cycle check failed");

// The consequent must hold starting in the cycle after the antecedent.
`define BLAS1VE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blas1 vector engine: next-cycle check failed");

`endif

/* rtl/blas1ve_pkg.sv */
package blas1ve_pkg;

    // Fixed-point format: Q(32-F).F elements, Q(64-2F).2F sums.
    localparam int FRAC_BITS = 16;

    // Port widths.
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 96;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_COEF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_COEF  = 2'd2;

    // Reset value of alpha and beta: 1.0 in Q.F.
    localparam logic signed [31:0] COEF_ONE = 32'sd1 <<< FRAC_BITS;

    // Saturation limits.
    localparam logic signed [63:0] SAT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [31:0] SAT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT32_MIN = 32'sh8000_0000;

    // Operation codes of the op_mode register.
    typedef enum logic [2:0] {
        MODE_DOT       = 3'd0,
        MODE_NORM_SQ   = 3'd1,
        MODE_AXPY      = 3'd2,
        MODE_AXPBY     = 3'd3,
        MODE_SCAL      = 3'd4,
        MODE_COPY      = 3'd5,
        MODE_AXPY_NORM = 3'd6
    } op_mode_t;

    // Operand pairs of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_X_Y,
        MUL_X_X,
        MUL_ALPHA_X,
        MUL_BETA_Y,
        MUL_YNEW_SQ
    } mul_sel_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_COMBINE,
        ST_SQUARE,
        ST_FINISH
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        mul_sel_t mul_sel;
        logic     load_a;
        logic     load_b;
        logic     combine;
        logic     finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_mode_t mode;
        logic     out_free;
    } dp_status_t;

endpackage

/* rtl/blas1ve_ctrl.sv */
module blas1ve_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  blas1ve_pkg::dp_status_t status,
    output blas1ve_pkg::dp_cmd_t    cmd
);
    import blas1ve_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: the route through the states depends on the item's mode.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                if (status.mode == MODE_AXPBY)
                begin
                    state_next = ST_MUL_B;
                end
                else if (status.mode inside {MODE_AXPY, MODE_SCAL, MODE_AXPY_NORM})
                begin
                    state_next = ST_COMBINE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL_B:
            begin
                state_next = ST_COMBINE;
            end
            ST_COMBINE:
            begin
                if (status.mode == MODE_AXPY_NORM)
                begin
                    state_next = ST_SQUARE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SQUARE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake and datapath commands.
    always_comb
    begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.mul_sel = MUL_ALPHA_X;
        cmd.load_a  = 1'b0;
        cmd.load_b  = 1'b0;
        cmd.combine = 1'b0;
        cmd.finish  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_MUL_A:
            begin
                cmd.load_a = 1'b1;
                if (status.mode == MODE_DOT)
                begin
                    cmd.mul_sel = MUL_X_Y;
                end
                else if (status.mode == MODE_NORM_SQ)
                begin
                    cmd.mul_sel = MUL_X_X;
                end
                else
                begin
                    cmd.mul_sel = MUL_ALPHA_X;
                end
            end
            ST_MUL_B:
            begin
                cmd.mul_sel = MUL_BETA_Y;
                cmd.load_b  = 1'b1;
            end
            ST_COMBINE:
            begin
                cmd.combine = 1'b1;
            end
            ST_SQUARE:
            begin
                cmd.mul_sel = MUL_YNEW_SQ;
                cmd.load_a  = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/blas1ve_dp.sv */
module blas1ve_dp #(
    parameter int FRAC_BITS = blas1ve_pkg::FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [blas1ve_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [blas1ve_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // s_tdata fields from bit 0: x_value[31:0], y_value[31:0].
    input  logic [blas1ve_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser fields from bit 0: in_reduction.
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata fields from bit 0: y_result[31:0], sum_result[63:0].
    output logic [blas1ve_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                                m_tlast,
    // m_tuser fields from bit 0: saturated.
    output logic                                m_tuser,
    input  blas1ve_pkg::dp_cmd_t                cmd,
    output blas1ve_pkg::dp_status_t             status
);
    import blas1ve_pkg::*;

    // Reset value of alpha and beta: 1.0 in Q.F.
    localparam logic signed [31:0] COEF_RESET = 32'sd1 <<< FRAC_BITS;

    // Configuration registers.
    op_mode_t           mode_cfg_reg;
    op_mode_t           mode_cfg_next;
    logic signed [31:0] alpha_reg;
    logic signed [31:0] alpha_next;
    logic signed [31:0] beta_reg;
    logic signed [31:0] beta_next;

    // Captured item.
    op_mode_t           mode_reg;
    op_mode_t           mode_next;
    logic signed [31:0] x_reg;
    logic signed [31:0] x_next;
    logic signed [31:0] y_reg;
    logic signed [31:0] y_next;
    logic               red_reg;
    logic               red_next;
    logic               last_reg;
    logic               last_next;

    // Work registers.
    logic signed [63:0] prod_a_reg;
    logic signed [63:0] prod_a_next;
    logic signed [63:0] prod_b_reg;
    logic signed [63:0] prod_b_next;
    logic signed [31:0] ynew_reg;
    logic signed [31:0] ynew_next;
    logic               sat_reg;
    logic               sat_next;
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;

    // Output register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] out_y_reg;
    logic signed [31:0] out_y_next;
    logic signed [63:0] out_sum_reg;
    logic signed [63:0] out_sum_next;
    logic               out_last_reg;
    logic               out_last_next;
    logic               out_sat_reg;
    logic               out_sat_next;

    // Combinational datapath signals.
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic signed [63:0] y_wide;
    logic signed [63:0] addend;
    logic        [64:0] comb_sum;
    logic               comb_ovf;
    logic signed [63:0] comb_wide;
    logic signed [63:0] comb_q;
    logic               q_ovf;
    logic signed [31:0] comb_y;
    logic               add_en;
    logic        [64:0] acc_sum;
    logic               acc_ovf;
    logic signed [63:0] acc_new;
    logic signed [31:0] y_out;

    // Configuration writes; an unknown index is ignored.
    always_comb
    begin
        mode_cfg_next = mode_cfg_reg;
        alpha_next    = alpha_reg;
        beta_next     = beta_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_OP_MODE:    mode_cfg_next = op_mode_t'(cfg_wdata[2:0]);
                CFG_ALPHA_COEF: alpha_next    = cfg_wdata;
                CFG_BETA_COEF:  beta_next     = cfg_wdata;
                default:        mode_cfg_next = mode_cfg_reg;
            endcase
        end
    end

    // Item capture.
    always_comb
    begin
        mode_next = mode_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        red_next  = red_reg;
        last_next = last_reg;
        if (cmd.capture)
        begin
            mode_next = mode_cfg_reg;
            x_next    = s_tdata[31:0];
            y_next    = s_tdata[63:32];
            red_next  = s_tuser;
            last_next = s_tlast;
        end
    end

    // Shared 32 x 32 signed multiplier; its product is always registered.
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_X_Y:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
            MUL_X_X:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            MUL_ALPHA_X:
            begin
                mul_a = alpha_reg;
                mul_b = x_reg;
            end
            MUL_BETA_Y:
            begin
                mul_a = beta_reg;
                mul_b = y_reg;
            end
            MUL_YNEW_SQ:
            begin
                mul_a = ynew_reg;
                mul_b = ynew_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
        endcase
    end

    assign mul_p       = mul_a * mul_b;
    assign prod_a_next = cmd.load_a ? mul_p : prod_a_reg;
    assign prod_b_next = cmd.load_b ? mul_p : prod_b_reg;

    // Second term of the new y: beta*y, y scaled to Q.2F, or nothing.
    assign y_wide = {{32{y_reg[31]}}, y_reg};

    always_comb
    begin
        case (mode_reg)
            MODE_AXPBY:     addend = prod_b_reg;
            MODE_AXPY:      addend = y_wide <<< FRAC_BITS;
            MODE_AXPY_NORM: addend = y_wide <<< FRAC_BITS;
            default:        addend = '0;
        endcase
    end

    // Saturating add, floor shift back to Q.F, then clamp to 32 bits.
    assign comb_sum  = {prod_a_reg[63], prod_a_reg} + {addend[63], addend};
    assign comb_ovf  = comb_sum[64] ^ comb_sum[63];
    assign comb_wide = comb_ovf ? (comb_sum[64] ? SAT64_MIN : SAT64_MAX)
                                : $signed(comb_sum[63:0]);
    assign comb_q    = comb_wide >>> FRAC_BITS;
    assign q_ovf     = (comb_q[63:31] != '0) && (comb_q[63:31] != '1);
    assign comb_y    = q_ovf ? (comb_q[63] ? SAT32_MIN : SAT32_MAX) : comb_q[31:0];

    assign ynew_next = cmd.combine ? comb_y : ynew_reg;

    // The flag records any clamp of the item's combine step; the accumulator clamp is added at the output.
    always_comb
    begin
        sat_next = sat_reg;
        if (cmd.capture)
        begin
            sat_next = 1'b0;
        end
        else if (cmd.combine)
        begin
            sat_next = comb_ovf | q_ovf;
        end
    end

    // Accumulate the product of a reduction item with saturation.
    assign add_en  = red_reg && (mode_reg inside {MODE_DOT, MODE_NORM_SQ, MODE_AXPY_NORM});
    assign acc_sum = {acc_reg[63], acc_reg}
                   + (add_en ? {prod_a_reg[63], prod_a_reg} : 65'd0);
    assign acc_ovf = acc_sum[64] ^ acc_sum[63];
    assign acc_new = acc_ovf ? (acc_sum[64] ? SAT64_MIN : SAT64_MAX)
                             : $signed(acc_sum[63:0]);

    // A last item reports the sum and clears the accumulator.
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.finish)
        begin
            acc_next = last_reg ? '0 : acc_new;
        end
    end

    // Element result by mode.
    always_comb
    begin
        case (mode_reg)
            MODE_AXPY:      y_out = ynew_reg;
            MODE_AXPBY:     y_out = ynew_reg;
            MODE_SCAL:      y_out = ynew_reg;
            MODE_AXPY_NORM: y_out = ynew_reg;
            MODE_COPY:      y_out = x_reg;
            default:        y_out = y_reg;
        endcase
    end

    // Output register: loaded when the slot is empty or being emptied.
    assign status.out_free = !out_valid_reg || m_tready;
    assign status.mode     = mode_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_y_next     = out_y_reg;
        out_sum_next   = out_sum_reg;
        out_last_next  = out_last_reg;
        out_sat_next   = out_sat_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_y_next     = y_out;
            out_sum_next   = last_reg ? acc_new : '0;
            out_last_next  = last_reg;
            out_sat_next   = sat_reg | (add_en & acc_ovf);
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_cfg_reg  <= MODE_DOT;
            alpha_reg     <= COEF_RESET;
            beta_reg      <= COEF_RESET;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_cfg_reg  <= mode_cfg_next;
            alpha_reg     <= alpha_next;
            beta_reg      <= beta_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        red_reg      <= red_next;
        last_reg     <= last_next;
        prod_a_reg   <= prod_a_next;
        prod_b_reg   <= prod_b_next;
        ynew_reg     <= ynew_next;
        sat_reg      <= sat_next;
        out_y_reg    <= out_y_next;
        out_sum_reg  <= out_sum_next;
        out_last_reg <= out_last_next;
        out_sat_reg  <= out_sat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_sum_reg, out_y_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_sat_reg;

endmodule

/* rtl/blas1_vector_engine_core.sv */
// Streaming BLAS level-1 engine in signed fixed point (Q16.16 elements, Q32.32
// sums at the default FRAC_BITS of 16). Each item carries one x, y element pair
// and yields one item with the updated y element; on an item marked last it also
// carries the finished sum of the reduction modes and clears the accumulator.
// Items are handled one at a time through a single shared 32 x 32 multiplier
// under a small sequencer. After IDLE an item runs MUL_A, FINISH (dot, norm_sq,
// copy); MUL_A, COMBINE, FINISH (axpy, scal); MUL_A, MUL_B, COMBINE, FINISH
// (axpby); MUL_A, COMBINE, SQUARE, FINISH (fused axpy-norm). FINISH waits
// while the output register is full; that register lets a new item be taken
// while the previous result waits. Write configuration only while idle.
module blas1_vector_engine_core #(
    parameter int FRAC_BITS = blas1ve_pkg::FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: 0 op_mode, 1 alpha_coef, 2 beta_coef.
    input  logic                                cfg_we,
    input  logic [blas1ve_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [blas1ve_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata fields from bit 0: x_value[31:0], y_value[31:0].
    input  logic [blas1ve_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser fields from bit 0: in_reduction.
    input  logic                                s_tuser,
    // s_tlast: last_item.
    input  logic                                s_tlast,
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata fields from bit 0: y_result[31:0], sum_result[63:0].
    output logic [blas1ve_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tlast: sum_valid.
    output logic                                m_tlast,
    // m_tuser fields from bit 0: saturated.
    output logic                                m_tuser
);
    import blas1ve_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    blas1ve_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic, accumulator and output register.
    blas1ve_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* rtl/blas1ve_checker.sv */
`include "blas1_vector_engine_core_defines.svh"

module blas1ve_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [blas1ve_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                                m_tlast,
    input logic                                m_tuser
);
    // Whole result item as seen on the output.
    logic [blas1ve_pkg::M_TDATA_W+1:0] m_word;

    assign m_word = {m_tuser, m_tlast, m_tdata};

    // Each accepted item keeps s_tready low while it passes through the sequencer, before the next is taken.
    `BLAS1VE_ASSERT_NEXT(ast_item_spacing, s_tvalid && s_tready, !s_tready ##1 !s_tready)

    // The sum field is zero on every item that does not close a vector.
    `BLAS1VE_ASSERT_SAME(ast_sum_only_on_last, m_tvalid && !m_tlast, m_tdata[95:32] == '0)

    // A stalled result item keeps its contents.
    `BLAS1VE_ASSERT_NEXT(ast_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_word))

endmodule

bind blas1_vector_engine_core blas1ve_checker u_checker (.*);
